// ===== rtl/ptwl_pkg.sv =====
// ---------------------------------------------------------------------------
// ptwl_pkg
// Types, constants and the control store of the tuning word loader.
// ---------------------------------------------------------------------------
package ptwl_pkg;

  // dial limit and arithmetic constants
  localparam logic [23:0] FREQ_MAX       = 24'd9999999;
  localparam logic [10:0] KHZ_OFFSET     = 11'd560;
  localparam logic [3:0]  KHZ_FOLD_DIGIT = 4'd5;     // 500 as a hundreds digit
  localparam logic [7:0]  LOOP2_LOW_ADD  = 8'd12;
  localparam logic [7:0]  LOOP2_HIGH_SUB = 8'd18;
  localparam logic [7:0]  BAND_SPLIT     = 8'd6;
  localparam logic [7:0]  DIGIT_LATCH    = 8'd112;

  // c/5 as (c * 205) >> 10, exact for c below 1024
  localparam logic [17:0] RECIP5         = 18'd205;
  localparam int          RECIP5_SHIFT   = 10;

  // x/10 as (x * 13421773) >> 27, exact for x below 2^26
  localparam logic [23:0] RECIP10        = 24'd13421773;
  localparam int          RECIP10_SHIFT  = 27;

  // strobe codes on strobe_res
  localparam logic [2:0] STB_BAND   = 3'd0;
  localparam logic [2:0] STB_LOOP1  = 3'd1;
  localparam logic [2:0] STB_LOOP2  = 3'd2;
  localparam logic [2:0] STB_NONE   = 3'd3;
  localparam logic [2:0] STB_PRESET = 3'd4;

  // opcodes
  localparam logic OP_TUNE  = 1'b0;
  localparam logic OP_TABLE = 1'b1;

  // decimal conversion: seven digits, one divide by ten each
  localparam int DIGIT_STEPS = 7;

  // control store
  localparam int PC_W = 4;

  typedef enum logic [3:0] {
    UOP_SEARCH,
    UOP_DIGIT,
    UOP_BAND,
    UOP_WORDS,
    UOP_KHZ,
    UOP_QUOT,
    UOP_COARSE,
    UOP_DLOAD,
    UOP_HALT
  } uop_t;

  typedef struct packed {
    uop_t       uop;
    logic [2:0] strb;   // strobe code of any write this step makes
    logic       lsd;    // digit load takes the 10 Hz digit
    logic       fin;    // step ends the run
  } uword_t;

  // microprogram of one tuning run
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{uop: UOP_HALT, strb: STB_NONE, lsd: 1'b0, fin: 1'b1};
    case (pc)
      4'd0: w = '{uop: UOP_SEARCH, strb: STB_NONE,   lsd: 1'b0, fin: 1'b0};
      4'd1: w = '{uop: UOP_DIGIT,  strb: STB_NONE,   lsd: 1'b0, fin: 1'b0};
      4'd2: w = '{uop: UOP_BAND,   strb: STB_BAND,   lsd: 1'b0, fin: 1'b0};
      4'd3: w = '{uop: UOP_WORDS,  strb: STB_NONE,   lsd: 1'b0, fin: 1'b0};
      4'd4: w = '{uop: UOP_KHZ,    strb: STB_LOOP1,  lsd: 1'b0, fin: 1'b0};
      4'd5: w = '{uop: UOP_QUOT,   strb: STB_NONE,   lsd: 1'b0, fin: 1'b0};
      4'd6: w = '{uop: UOP_COARSE, strb: STB_LOOP2,  lsd: 1'b0, fin: 1'b0};
      4'd7: w = '{uop: UOP_DLOAD,  strb: STB_NONE,   lsd: 1'b0, fin: 1'b0};
      4'd8: w = '{uop: UOP_DLOAD,  strb: STB_PRESET, lsd: 1'b1, fin: 1'b1};
      default: w = '{uop: UOP_HALT, strb: STB_NONE, lsd: 1'b0, fin: 1'b1};
    endcase
    return w;
  endfunction

  // latch byte: address 48, 32, 16, 0 for nibble 0..3, data in the low nibble
  function automatic logic [7:0] latch_byte(input logic [1:0] sub, input logic [3:0] nib);
    return {2'b00, ~sub, nib};
  endfunction

endpackage

// ===== rtl/pll_tuning_word_loader.sv =====
// ---------------------------------------------------------------------------
// pll_tuning_word_loader
// Turns a dial frequency into band latch and loop word writes, run by a
// small microprogram over a plain datapath.
// ---------------------------------------------------------------------------
// A table write (opcode 1) is taken and busy stays low. A tune
// to the last tuned frequency is taken and gives nothing. Any other tune
// raises busy for a run of the microprogram: a band search over 1 to
// TABLE_ENTRIES range entries, seven divides by ten for the decimal
// conversion (one divide by ten a cycle), then the writes and bookkeeping
// steps of the microprogram. Writes
// come out one per cycle on valid, in order, and must be taken as they come:
// the block does not wait for the receiver. The last write of a run has last
// high and busy drops with it.
module pll_tuning_word_loader #(
  parameter int TABLE_ENTRIES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        opcode,
  input  logic [23:0] frequency,
  input  logic [3:0]  table_index,
  input  logic [23:0] range_low,
  input  logic [23:0] range_high,
  input  logic [7:0]  band_code,
  output logic        valid,
  output logic [7:0]  port_value,
  output logic [2:0]  strobe_res,
  output logic        last
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // range table
  logic [23:0] tab_lo   [TABLE_ENTRIES];
  logic [23:0] tab_hi   [TABLE_ENTRIES];
  logic [7:0]  tab_code [TABLE_ENTRIES];

  // sequencer and datapath registers
  logic                      running, running_next;
  logic [ptwl_pkg::PC_W-1:0] pc, pc_next;
  logic [IDX_W-1:0]          sidx, sidx_next;
  logic [2:0]                bcnt, bcnt_next;
  logic [1:0]                sub, sub_next;
  logic [23:0]               freq;
  logic [23:0]               rem, rem_next;
  logic [27:0]               digits, digits_next;
  logic [10:0]               w_reg, w_next;
  logic [9:0]                c_reg, c_next;
  logic [7:0]                v_reg, v_next;

  // tuning history
  logic [7:0]  current_band, current_band_next;
  logic [7:0]  last_band, last_band_next;
  logic [10:0] last_khz_word, last_khz_word_next;
  logic [9:0]  last_coarse_freq, last_coarse_freq_next;
  logic [23:0] last_frequency, last_frequency_next;

  // output register
  logic       valid_next;
  logic [7:0] port_value_next;
  logic [2:0] strobe_res_next;
  logic       last_next;

  ptwl_pkg::uword_t uw;
  logic        accept;
  logic        tune_go;
  logic        hit;
  logic [47:0] dprod;
  logic [23:0] dq;
  logic [23:0] dten;
  logic [3:0]  dr;
  logic [3:0]  d6, d5, d4, d3, d2, d1, d0, d4f;
  logic [17:0] prod;
  logic [7:0]  quot;
  logic [3:0]  khz_nib, crs_nib;

  assign busy    = running;
  assign accept  = start && !running;
  assign tune_go = accept && (opcode == ptwl_pkg::OP_TUNE) && (frequency != last_frequency);
  assign uw      = ptwl_pkg::ucode(pc);

  // bcd digits, most significant first
  assign d6 = digits[27:24];
  assign d5 = digits[23:20];
  assign d4 = digits[19:16];
  assign d3 = digits[15:12];
  assign d2 = digits[11:8];
  assign d1 = digits[7:4];
  assign d0 = digits[3:0];

  // datapath terms
  assign hit   = (freq >= tab_lo[sidx]) && (freq <= tab_hi[sidx]);
  assign dprod = 48'(rem) * 48'(ptwl_pkg::RECIP10);
  assign dq    = 24'(dprod >> ptwl_pkg::RECIP10_SHIFT);
  assign dten  = (dq << 3) + (dq << 1);
  assign dr    = rem[3:0] - dten[3:0];
  assign d4f   = (d4 >= ptwl_pkg::KHZ_FOLD_DIGIT) ? (d4 - ptwl_pkg::KHZ_FOLD_DIGIT) : d4;
  assign prod  = 18'(c_reg) * ptwl_pkg::RECIP5;
  assign quot  = prod[ptwl_pkg::RECIP5_SHIFT +: 8];

  // nibble of each loop word for the current write
  always_comb begin
    case (sub)
      2'd0:    khz_nib = 4'h0;
      2'd1:    khz_nib = {1'b0, w_reg[10:8]};
      2'd2:    khz_nib = w_reg[7:4];
      default: khz_nib = w_reg[3:0];
    endcase
    case (sub)
      2'd2:    crs_nib = v_reg[7:4];
      2'd3:    crs_nib = v_reg[3:0];
      default: crs_nib = 4'h0;
    endcase
  end

  // microprogram step
  always_comb begin
    running_next          = running;
    pc_next               = pc;
    sidx_next             = sidx;
    bcnt_next             = bcnt;
    sub_next              = sub;
    rem_next              = rem;
    digits_next           = digits;
    w_next                = w_reg;
    c_next                = c_reg;
    v_next                = v_reg;
    current_band_next     = current_band;
    last_band_next        = last_band;
    last_khz_word_next    = last_khz_word;
    last_coarse_freq_next = last_coarse_freq;
    last_frequency_next   = last_frequency;
    valid_next            = 1'b0;
    port_value_next       = port_value;
    strobe_res_next       = strobe_res;
    last_next             = 1'b0;

    if (running) begin
      case (uw.uop)
        // first entry holding the frequency sets the band
        ptwl_pkg::UOP_SEARCH: begin
          if (hit) begin
            current_band_next = tab_code[sidx];
            pc_next           = pc + 1'b1;
          end else if (sidx == LAST_IDX) begin
            pc_next = pc + 1'b1;
          end else begin
            sidx_next = sidx + 1'b1;
          end
        end
        // one divide by ten per cycle, least significant digit first
        ptwl_pkg::UOP_DIGIT: begin
          rem_next    = dq;
          digits_next = {dr, digits[27:4]};
          if (bcnt == 3'(ptwl_pkg::DIGIT_STEPS - 1)) begin
            pc_next = pc + 1'b1;
          end else begin
            bcnt_next = bcnt + 1'b1;
          end
        end
        // band byte when it changed
        ptwl_pkg::UOP_BAND: begin
          if (current_band != last_band) begin
            valid_next      = 1'b1;
            port_value_next = current_band;
            strobe_res_next = uw.strb;
            last_band_next  = current_band;
          end
          pc_next = pc + 1'b1;
        end
        // loop 1 word and coarse count from the digits
        ptwl_pkg::UOP_WORDS: begin
          w_next  = 11'(d4f) * 11'd100 + 11'(d3) * 11'd10 + 11'(d2) + ptwl_pkg::KHZ_OFFSET;
          c_next  = 10'(d6) * 10'd100 + 10'(d5) * 10'd10 + 10'(d4);
          pc_next = pc + 1'b1;
        end
        // loop 1 word, four writes when it changed
        ptwl_pkg::UOP_KHZ: begin
          if (w_reg != last_khz_word) begin
            valid_next      = 1'b1;
            port_value_next = ptwl_pkg::latch_byte(sub, khz_nib);
            strobe_res_next = uw.strb;
            if (sub == 2'd3) begin
              last_khz_word_next = w_reg;
              sub_next           = 2'd0;
              pc_next            = pc + 1'b1;
            end else begin
              sub_next = sub + 1'b1;
            end
          end else begin
            pc_next = pc + 1'b1;
          end
        end
        // loop 2 word from the coarse count and band
        ptwl_pkg::UOP_QUOT: begin
          v_next  = (current_band < ptwl_pkg::BAND_SPLIT) ? (quot + ptwl_pkg::LOOP2_LOW_ADD)
                                                         : (quot - ptwl_pkg::LOOP2_HIGH_SUB);
          pc_next = pc + 1'b1;
        end
        // loop 2 word, four writes when the coarse count changed
        ptwl_pkg::UOP_COARSE: begin
          if (c_reg != last_coarse_freq) begin
            valid_next      = 1'b1;
            port_value_next = ptwl_pkg::latch_byte(sub, crs_nib);
            strobe_res_next = uw.strb;
            if (sub == 2'd3) begin
              last_coarse_freq_next = c_reg;
              sub_next              = 2'd0;
              pc_next               = pc + 1'b1;
            end else begin
              sub_next = sub + 1'b1;
            end
          end else begin
            pc_next = pc + 1'b1;
          end
        end
        // 100 Hz and 10 Hz digit loads
        ptwl_pkg::UOP_DLOAD: begin
          valid_next      = 1'b1;
          port_value_next = ptwl_pkg::DIGIT_LATCH + {4'h0, (uw.lsd ? d0 : d1)};
          strobe_res_next = uw.strb;
          last_next       = uw.fin;
          if (uw.fin) begin
            last_frequency_next = freq;
            running_next        = 1'b0;
          end else begin
            pc_next = pc + 1'b1;
          end
        end
        default: begin
          running_next = 1'b0;
        end
      endcase
    end
  end

  // control and history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      running          <= 1'b0;
      pc               <= '0;
      valid            <= 1'b0;
      last             <= 1'b0;
      current_band     <= '0;
      last_band        <= '0;
      last_khz_word    <= '0;
      last_coarse_freq <= '0;
      last_frequency   <= '0;
    end else if (tune_go) begin
      running <= 1'b1;
      pc      <= '0;
      valid   <= 1'b0;
      last    <= 1'b0;
    end else begin
      running          <= running_next;
      pc               <= pc_next;
      valid            <= valid_next;
      last             <= last_next;
      current_band     <= current_band_next;
      last_band        <= last_band_next;
      last_khz_word    <= last_khz_word_next;
      last_coarse_freq <= last_coarse_freq_next;
      last_frequency   <= last_frequency_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (tune_go) begin
      freq <= frequency;
      rem  <= (frequency > ptwl_pkg::FREQ_MAX) ? ptwl_pkg::FREQ_MAX : frequency;
      sidx <= '0;
      bcnt <= '0;
      sub  <= '0;
    end else begin
      rem  <= rem_next;
      sidx <= sidx_next;
      bcnt <= bcnt_next;
      sub  <= sub_next;
    end
    digits     <= digits_next;
    w_reg      <= w_next;
    c_reg      <= c_next;
    v_reg      <= v_next;
    port_value <= port_value_next;
    strobe_res <= strobe_res_next;
  end

  // range table writes, indexes past the table are dropped
  always_ff @(posedge clk) begin
    if (accept && (opcode == ptwl_pkg::OP_TABLE) &&
        ({28'd0, table_index} < 32'(TABLE_ENTRIES))) begin
      tab_lo[IDX_W'(table_index)]   <= range_low;
      tab_hi[IDX_W'(table_index)]   <= range_high;
      tab_code[IDX_W'(table_index)] <= band_code;
    end
  end

endmodule
